// File: rtl/sukt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted unique key table package
// Field widths, operation codes and status codes shared by the block.
// ---------------------------------------------------------------------------
package sukt_pkg;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 16;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_LOOKUP = 2'd1;
	localparam op_t OP_DELETE = 2'd2;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_DUP     = 2'd1;
	localparam status_t ST_MISSING = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

endpackage

// File: rtl/sukt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sukt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sorted_unique_key_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted unique key table
// Holds distinct keys in ascending order in one RAM; insert, lookup, delete.
// ---------------------------------------------------------------------------
// A request word (operation, key) is taken at a clock edge where start is
// high and busy is low. One request is served at a time; busy stays high
// until its result is produced. The result word (status, position,
// entry_count) is shown for exactly one cycle with done high, and a new
// request may be taken in that same cycle.
// The keys sit in a single RAM with one read and one write port and
// registered read data. A lower-bound binary search spends an address
// step (S_SRCH) and a compare step (S_CMP) on each halving, then reads and
// checks the found entry (S_SRCH, S_CHK). Insert and delete then move
// every larger key by one place, one entry per cycle with read and write
// overlapped, plus pipeline fill and, for insert, key placement (S_PUT).
// Reset empties the table at once: the entry count is cleared and the RAM
// contents are left as they are, since only entries below the count are
// ever used. The receiver cannot hold results off.
// ---------------------------------------------------------------------------
module sorted_unique_key_table_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sukt_pkg::op_t     operation,
	input  sukt_pkg::key_t    key,
	output logic              done,
	output sukt_pkg::status_t status,
	output sukt_pkg::pos_t    position,
	output sukt_pkg::count_t  entry_count
);

	import sukt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SRCH  = 6'b000010,
		S_CMP   = 6'b000100,
		S_CHK   = 6'b001000,
		S_SHIFT = 6'b010000,
		S_PUT   = 6'b100000
	} state_t;

	state_t          state_q;
	op_t             op_q;
	key_t            key_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [AW-1:0]   src_q;
	logic [AW-1:0]   last_q;
	logic            up_q;
	logic            issue_q;
	logic            pend_s1;
	logic [AW-1:0]   wa_s1;

	logic [CW-1:0]   mid;
	logic            hit;
	logic [AW-1:0]   raddr;
	logic [KEY_W-1:0] rdata;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [KEY_W-1:0] wdata;

	assign busy = (state_q != S_IDLE);
	assign mid  = lo_q + ((hi_q - lo_q) >> 1);
	assign hit  = (lo_q < count_q) && (rdata == key_q);

	always_comb begin
		if (state_q == S_SHIFT) begin
			raddr = src_q;
		end else if (lo_q < hi_q) begin
			raddr = mid[AW-1:0];
		end else begin
			raddr = lo_q[AW-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = wa_s1;
		wdata = rdata;
		if (state_q == S_SHIFT && pend_s1) begin
			we = 1'b1;
		end else if (state_q == S_PUT) begin
			we    = 1'b1;
			waddr = lo_q[AW-1:0];
			wdata = key_q;
		end
	end

	sukt_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_q     <= 1'b0;
			pend_s1     <= 1'b0;
			done        <= 1'b0;
			status      <= ST_OK;
			position    <= '0;
			entry_count <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						key_q   <= key;
						lo_q    <= '0;
						hi_q    <= count_q;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CMP: begin
					if (rdata < key_q) begin
						lo_q <= mid + ONE_C;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_CHK: begin
					state_q     <= S_IDLE;
					done        <= 1'b1;
					status      <= ST_OK;
					position    <= POS_W'(lo_q);
					entry_count <= COUNT_W'(count_q);
					if (op_q == OP_INSERT) begin
						if (hit) begin
							status <= ST_DUP;
						end else if (count_q >= DEPTH_C) begin
							status   <= ST_FULL;
							position <= '0;
						end else begin
							done <= 1'b0;
							if (count_q > lo_q) begin
								src_q   <= AW'(count_q - ONE_C);
								last_q  <= lo_q[AW-1:0];
								up_q    <= 1'b1;
								issue_q <= 1'b1;
								state_q <= S_SHIFT;
							end else begin
								state_q <= S_PUT;
							end
						end
					end else if (op_q == OP_DELETE) begin
						if (hit) begin
							if (count_q > lo_q + ONE_C) begin
								done    <= 1'b0;
								src_q   <= AW'(lo_q + ONE_C);
								last_q  <= AW'(count_q - ONE_C);
								up_q    <= 1'b0;
								issue_q <= 1'b1;
								state_q <= S_SHIFT;
							end else begin
								count_q     <= count_q - ONE_C;
								entry_count <= COUNT_W'(count_q - ONE_C);
							end
						end else begin
							status   <= ST_MISSING;
							position <= '0;
						end
					end else begin
						if (!hit) begin
							status   <= ST_MISSING;
							position <= '0;
						end
					end
				end
				S_SHIFT: begin
					pend_s1 <= issue_q;
					wa_s1   <= up_q ? src_q + AW'(1) : src_q - AW'(1);
					if (issue_q) begin
						if (src_q == last_q) begin
							issue_q <= 1'b0;
						end else begin
							src_q <= up_q ? src_q - AW'(1) : src_q + AW'(1);
						end
					end
					if (pend_s1 && !issue_q) begin
						if (up_q) begin
							state_q <= S_PUT;
						end else begin
							state_q     <= S_IDLE;
							done        <= 1'b1;
							status      <= ST_OK;
							position    <= POS_W'(lo_q);
							count_q     <= count_q - ONE_C;
							entry_count <= COUNT_W'(count_q - ONE_C);
						end
					end
				end
				S_PUT: begin
					state_q     <= S_IDLE;
					done        <= 1'b1;
					status      <= ST_OK;
					position    <= POS_W'(lo_q);
					count_q     <= count_q + ONE_C;
					entry_count <= COUNT_W'(count_q + ONE_C);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
